>>> rtl/rvn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rvn_pkg;

  typedef enum logic [1:0] {
    NORM_SUM    = 2'd0,
    NORM_EUCLID = 2'd1,
    NORM_MAX    = 2'd2
  } norm_mode_e;

  typedef enum logic {
    CFG_NORM_MODE     = 1'b0,
    CFG_SOURCE_SELECT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_FINISH,
    BK_SQRT
  } back_state_e;

  typedef struct packed {
    logic clamped;
    logic last;
  } elem_flags_t;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 2;
  localparam int unsigned IN_W        = 32;
  localparam int unsigned NORM_W      = 48;
  localparam int unsigned SUM_W       = 64;
  localparam int unsigned ACC_W       = SUM_W + 1;
  localparam int unsigned ROOT_W      = SUM_W / 2;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [NORM_W-1:0] NORM_MAX48 = '1;

  localparam norm_mode_e NORM_MODE_RESET = NORM_EUCLID;

endpackage
`default_nettype wire

>>> rtl/rvn_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rvn_front import rvn_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic [IN_W-1:0]       rhs_value_i,
  input  wire logic [IN_W-1:0]       product_value_i,
  input  wire logic                  last_element_i,
  input  wire logic                  source_select_i,
  output logic      [DATA_WIDTH-1:0] mag_o,
  output elem_flags_t                flags_o
);

  localparam logic [DATA_WIDTH-1:0] ElemHi = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] ElemLo = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic [DATA_WIDTH:0]   rhs_ext;
  logic [DATA_WIDTH:0]   prod_ext;
  logic [DATA_WIDTH:0]   diff;
  logic [DATA_WIDTH-1:0] elem;
  logic                  clamped;

  assign rhs_ext  = {rhs_value_i[DATA_WIDTH-1], rhs_value_i[DATA_WIDTH-1:0]};
  assign prod_ext = {product_value_i[DATA_WIDTH-1], product_value_i[DATA_WIDTH-1:0]};
  assign diff     = rhs_ext - prod_ext;

  // The residual is clamped to the signed element range when it overflows.
  always_comb begin
    elem    = rhs_value_i[DATA_WIDTH-1:0];
    clamped = 1'b0;
    if (!source_select_i) begin
      elem = diff[DATA_WIDTH-1:0];
      if (diff[DATA_WIDTH] != diff[DATA_WIDTH-1]) begin
        clamped = 1'b1;
        elem    = diff[DATA_WIDTH] ? ElemLo : ElemHi;
      end
    end
  end

  assign mag_o           = elem[DATA_WIDTH-1] ? ({DATA_WIDTH{1'b0}} - elem) : elem;
  assign flags_o.clamped = clamped;
  assign flags_o.last    = last_element_i;

endmodule
`default_nettype wire

>>> rtl/rvn_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module rvn_queue import rvn_pkg::*; #(
  parameter int unsigned WIDTH = 34
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0]    mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]   count_q, count_d;

  assign full_o  = (count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

>>> rtl/rvn_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module rvn_sqrt import rvn_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [SUM_W-1:0]  radicand_i,
  output logic                   done_o,
  output logic      [ROOT_W-1:0] root_o
);

  localparam int unsigned RemW = ROOT_W + 2;
  localparam int unsigned CntW = $clog2(ROOT_W);

  logic              busy_q;
  logic              done_q;
  logic [CntW-1:0]   cnt_q;
  logic [SUM_W-1:0]  rad_q;
  logic [ROOT_W-1:0] root_q;
  logic [RemW-1:0]   rem_q;
  logic [RemW-1:0]   rem_sh;
  logic [RemW-1:0]   trial;
  logic              ge;

  // One result bit per cycle: bring down two radicand bits and try the next digit.
  assign rem_sh = {rem_q[RemW-3:0], rad_q[SUM_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(ROOT_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[SUM_W-3:0], 2'b00};
      root_q <= {root_q[ROOT_W-2:0], ge};
      rem_q  <= ge ? (rem_sh - trial) : rem_sh;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

>>> rtl/rvn_back.sv
`timescale 1ns / 1ps
`default_nettype none
module rvn_back import rvn_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  q_empty_i,
  input  wire logic [DATA_WIDTH-1:0] q_mag_i,
  input  elem_flags_t                q_flags_i,
  output logic                       pop_o,
  input  norm_mode_e                 norm_mode_i,
  output logic                       out_valid_o,
  output logic      [NORM_W-1:0]     out_norm_o,
  output logic                       out_sat_o,
  input  wire logic                  out_ready_i
);

  back_state_e state_q, state_d;

  logic                    mv_q;
  logic [DATA_WIDTH-1:0]   m_mag_q;
  logic [2*DATA_WIDTH-1:0] m_sq_q;
  elem_flags_t             m_flags_q;

  logic [SUM_W-1:0]  sum_q;
  logic              ovf_q;
  logic [SUM_W-1:0]  acc_sum;
  logic              acc_ovf;
  logic [ACC_W-1:0]  sum_mag_ext;
  logic [ACC_W-1:0]  sum_sq_ext;
  logic              fin_sat;
  logic [NORM_W-1:0] fin_norm;

  logic              out_valid_q;
  logic [NORM_W-1:0] out_norm_q;
  logic              out_sat_q;
  logic              out_free;

  logic              take_m;
  logic              sqrt_start;
  logic              sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;
  logic              load_out;
  logic [NORM_W-1:0] load_norm;
  logic              load_sat;

  rvn_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sum_q),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign take_m   = mv_q && (state_q == BK_RUN);
  assign pop_o    = !q_empty_i && (!mv_q || take_m);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (pop_o) begin
      mv_q <= 1'b1;
    end else if (take_m) begin
      mv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      m_mag_q   <= q_mag_i;
      m_sq_q    <= q_mag_i * q_mag_i;
      m_flags_q <= q_flags_i;
    end
  end

  assign sum_mag_ext = {1'b0, sum_q} + ACC_W'(m_mag_q);
  assign sum_sq_ext  = {1'b0, sum_q} + ACC_W'(m_sq_q);

  always_comb begin
    acc_sum = sum_q;
    acc_ovf = ovf_q | m_flags_q.clamped;
    case (norm_mode_i)
      NORM_SUM: begin
        if (sum_mag_ext > ACC_W'(NORM_MAX48)) begin
          acc_sum = SUM_W'(NORM_MAX48);
          acc_ovf = 1'b1;
        end else begin
          acc_sum = sum_mag_ext[SUM_W-1:0];
        end
      end
      NORM_EUCLID: begin
        if (sum_sq_ext[SUM_W]) begin
          acc_sum = '1;
          acc_ovf = 1'b1;
        end else begin
          acc_sum = sum_sq_ext[SUM_W-1:0];
        end
      end
      default: begin
        if (SUM_W'(m_mag_q) > sum_q) begin
          acc_sum = SUM_W'(m_mag_q);
        end
      end
    endcase
  end

  assign fin_sat  = (sum_q > SUM_W'(NORM_MAX48));
  assign fin_norm = fin_sat ? NORM_MAX48 : sum_q[NORM_W-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_RUN: begin
        if (mv_q && m_flags_q.last) begin
          state_d = BK_FINISH;
        end
      end
      BK_FINISH: begin
        if (norm_mode_i == NORM_EUCLID) begin
          state_d = BK_SQRT;
        end else if (out_free) begin
          state_d = BK_RUN;
        end
      end
      BK_SQRT: begin
        if (sqrt_done && out_free) begin
          state_d = BK_RUN;
        end
      end
      default: state_d = BK_RUN;
    endcase
  end

  always_comb begin
    sqrt_start = 1'b0;
    load_out   = 1'b0;
    load_norm  = fin_norm;
    load_sat   = ovf_q | fin_sat;
    case (state_q)
      BK_FINISH: begin
        sqrt_start = (norm_mode_i == NORM_EUCLID);
        load_out   = (norm_mode_i != NORM_EUCLID) && out_free;
      end
      BK_SQRT: begin
        load_out  = sqrt_done && out_free;
        load_norm = NORM_W'(sqrt_root);
        load_sat  = ovf_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_RUN;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        sum_q <= '0;
        ovf_q <= 1'b0;
      end else if (take_m) begin
        sum_q <= acc_sum;
        ovf_q <= acc_ovf;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_norm_q <= load_norm;
      out_sat_q  <= load_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_norm_o  = out_norm_q;
  assign out_sat_o   = out_sat_q;

endmodule
`default_nettype wire

>>> rtl/residual_vector_norm_top.sv
// Residual vector norm over a stream of Q16.16 elements.
// The slave stream carries one element per request: tdata holds the right-hand
// side value in bits 31:0 and the matrix-product value in bits 63:32, and tlast
// marks the final element of a vector. The master stream carries one request
// per vector: tdata holds the 48-bit norm and tuser the saturation flag.
// The configuration channel writes the norm mode (index 0) and the source
// select (index 1); it is always ready, and the user must write it only while
// the block idles, which the block itself does not enforce. Elements enter a
// four-entry queue at one per cycle while it has room and the back end consumes
// one per cycle while it runs. For the 1-norm and the maximum the accumulated
// sum goes to the output register; for the 2-norm the bit-serial square root
// runs first, one result bit per cycle. During that time the queue fills and
// the input stalls. Reset clears the queue, the accumulator and the output
// valid flag and sets the Euclidean mode with the residual as source. When the
// receiver stalls, the result is held in the output register and the back end
// waits with the next finished vector; the queue then fills and tready falls.
`timescale 1ns / 1ps
`default_nettype none
module residual_vector_norm_top import rvn_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // rhs_value [31:0], product_value [63:32]
  input  wire logic [2*IN_W-1:0]      s_axis_tdata,
  input  wire logic                   s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // norm_value [47:0]
  output logic      [NORM_W-1:0]      m_axis_tdata,
  // saturated [0]
  output logic                        m_axis_tuser,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned QueueW = DATA_WIDTH + $bits(elem_flags_t);

  norm_mode_e norm_mode_q;
  logic       source_select_q;

  logic [DATA_WIDTH-1:0] f_mag;
  elem_flags_t           f_flags;
  logic                  q_push;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_empty;
  logic [QueueW-1:0]     q_data;
  logic [DATA_WIDTH-1:0] q_mag;
  elem_flags_t           q_flags;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_mode_q     <= NORM_MODE_RESET;
      source_select_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_NORM_MODE:     norm_mode_q     <= norm_mode_e'(cfg_data_i);
        CFG_SOURCE_SELECT: source_select_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  rvn_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .rhs_value_i     (s_axis_tdata[IN_W-1:0]),
    .product_value_i (s_axis_tdata[2*IN_W-1:IN_W]),
    .last_element_i  (s_axis_tlast),
    .source_select_i (source_select_q),
    .mag_o           (f_mag),
    .flags_o         (f_flags)
  );

  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full;

  rvn_queue #(
    .WIDTH (QueueW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  ({f_flags, f_mag}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_data),
    .empty_o (q_empty)
  );

  assign q_mag   = q_data[DATA_WIDTH-1:0];
  assign q_flags = elem_flags_t'(q_data[QueueW-1:DATA_WIDTH]);

  rvn_back #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_mag_i     (q_mag),
    .q_flags_i   (q_flags),
    .pop_o       (q_pop),
    .norm_mode_i (norm_mode_q),
    .out_valid_o (m_axis_tvalid),
    .out_norm_o  (m_axis_tdata),
    .out_sat_o   (m_axis_tuser),
    .out_ready_i (m_axis_tready)
  );

endmodule
`default_nettype wire

>>> rtl/rvn_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module rvn_checker import rvn_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic [2*IN_W-1:0]      s_axis_tdata,
  input wire logic                   s_axis_tlast,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [NORM_W-1:0]      m_axis_tdata,
  input wire logic                   m_axis_tuser,
  input wire logic                   cfg_valid_i,
  input wire logic                   cfg_ready_o,
  input wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  logic [CFG_DATA_W-1:0] mode_q;
  logic                  in_seen;

  assign in_seen = s_axis_tvalid && s_axis_tready && s_axis_tlast && (s_axis_tdata != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= CFG_DATA_W'(NORM_MODE_RESET);
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i == CFG_NORM_MODE)) begin
      mode_q <= cfg_data_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid && s_axis_tready)
    else $error("result or stall shown during reset");

  a_root_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (mode_q == CFG_DATA_W'(NORM_EUCLID)) |->
      (m_axis_tdata[NORM_W-1:ROOT_W] == '0) && !$isunknown(in_seen))
    else $error("square root wider than half the sum");

  // A sum carried over from another mode may be wider, and need not saturate.
  a_max_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && mode_q[1] && !m_axis_tuser |->
      m_axis_tdata[NORM_W-1:DATA_WIDTH] == '0)
    else $error("maximum magnitude exceeds the element range");

endmodule

bind residual_vector_norm_top rvn_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_checker (.*);
`default_nettype wire
